FILE: design/pvta_pkg.sv
package pvta_pkg;

    localparam int COORD_BITS   = 16;
    localparam int CORDIC_STEPS = 18;

    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int DOT_W    = PROD_W + 1;
    localparam int LEN_FRAC = 8;
    localparam int LEN_W    = DIFF_W + LEN_FRAC + 3;
    localparam int ANG_W    = 64;
    localparam int ANG_TOP  = 58;
    localparam int Z_W      = 34;
    localparam int T_W      = Z_W + 1;
    localparam int INV_W    = 28;
    localparam int MUL_W    = LEN_W - 1 + INV_W;
    localparam int LEN_SH   = 28 + LEN_FRAC;

    localparam logic [INV_W-1:0] INV_GAIN_Q28 = 28'd163008218;
    localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sd1073741824;

    // must stay a power of two
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic signed [ANG_W-1:0]  ax;
        logic signed [ANG_W-1:0]  ay;
        logic signed [Z_W-1:0]    az;
        logic signed [LEN_W-1:0]  lx;
        logic signed [LEN_W-1:0]  ly;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic                     lone;
        logic                     cz;
    } work_t;

    // arctangent of 2^-i, 2^32 per turn
    function automatic logic signed [Z_W-1:0] atan_turn(input int i);
        logic signed [Z_W-1:0] r;
        unique case (i)
            0:  r = 34'sd536870912;
            1:  r = 34'sd316933406;
            2:  r = 34'sd167458907;
            3:  r = 34'sd85004756;
            4:  r = 34'sd42667331;
            5:  r = 34'sd21354465;
            6:  r = 34'sd10679838;
            7:  r = 34'sd5340245;
            8:  r = 34'sd2670163;
            9:  r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            24: r = 34'sd41;
            25: r = 34'sd20;
            26: r = 34'sd10;
            27: r = 34'sd5;
            28: r = 34'sd3;
            29: r = 34'sd1;
            30: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/pvta_if.sv
interface pvta_vtx_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] prev_x;
    logic signed [15:0] prev_y;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic signed [15:0] next_x;
    logic signed [15:0] next_y;
    logic        lone_point;

    modport source (output valid, prev_x, prev_y, cur_x, cur_y, next_x, next_y, lone_point,
                    input ready);
    modport sink (input valid, prev_x, prev_y, cur_x, cur_y, next_x, next_y, lone_point,
                  output ready);
endinterface

interface pvta_res_if;
    logic        valid;
    logic        ready;
    logic signed [16:0] edge_dx;
    logic signed [16:0] edge_dy;
    logic [16:0] edge_length;
    logic [16:0] turn_angle;

    modport source (output valid, edge_dx, edge_dy, edge_length, turn_angle, input ready);
    modport sink (input valid, edge_dx, edge_dy, edge_length, turn_angle, output ready);
endinterface

FILE: design/pvta_front.sv
module pvta_front (
    input  logic             clk,
    input  logic             rst_n,
    pvta_vtx_if.sink         vtx,
    output pvta_pkg::work_t  q_data,
    output logic             q_valid,
    input  logic             q_ready
);

    localparam int DW = pvta_pkg::DIFF_W;
    localparam int PW = pvta_pkg::PROD_W;
    localparam int OW = pvta_pkg::DOT_W;
    localparam int LW = pvta_pkg::LEN_W;
    localparam int AW = pvta_pkg::ANG_W;
    localparam int CB = pvta_pkg::COORD_BITS;

    logic       fe;
    logic [7:1] v_reg;

    logic signed [DW-1:0] dx1_reg, dy1_reg, r1x1_reg, r1y1_reg, r2y1_reg;
    logic                 lone1_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [DW-1:0] dx2_reg, dy2_reg;
    logic                 lone2_reg;
    logic signed [OW-1:0] cross3_reg, dot3_reg;
    logic signed [LW-1:0] lx3_reg, ly3_reg;
    logic signed [DW-1:0] dx3_reg, dy3_reg;
    logic                 lone3_reg;
    pvta_pkg::work_t      w4_reg, w5_reg, w6_reg, w7_reg;
    pvta_pkg::work_t      w4_next, w5_next, w6_next, w7_next;
    logic [AW-1:0]        m4_reg, m5_reg, m5_next, m6_next;

    logic signed [CB-1:0] px, py, cx, cy, nx, ny;
    logic signed [LW-1:0] adx, ady;
    logic signed [AW-1:0] cw, dw;
    logic [AW-1:0]        mc, md;

    assign fe        = !v_reg[7] || q_ready;
    assign vtx.ready = fe;
    assign q_valid   = v_reg[7];
    assign q_data    = w7_reg;

    assign px = vtx.prev_x[CB-1:0];
    assign py = vtx.prev_y[CB-1:0];
    assign cx = vtx.cur_x[CB-1:0];
    assign cy = vtx.cur_y[CB-1:0];
    assign nx = vtx.next_x[CB-1:0];
    assign ny = vtx.next_y[CB-1:0];

    assign adx = (dx2_reg < 0) ? -LW'(dx2_reg) : LW'(dx2_reg);
    assign ady = (dy2_reg < 0) ? -LW'(dy2_reg) : LW'(dy2_reg);

    // magnitudes for the normalize shift
    always_comb
    begin
        cw = AW'(cross3_reg);
        dw = AW'(dot3_reg);
        mc = (cw < 0) ? AW'(-cw) : AW'(cw);
        md = (dw < 0) ? AW'(-dw) : AW'(dw);
        w4_next    = '0;
        w4_next.ax = dw;
        w4_next.ay = cw;
        w4_next.lx = lx3_reg;
        w4_next.ly = ly3_reg;
        w4_next.dx = dx3_reg;
        w4_next.dy = dy3_reg;
        w4_next.lone = lone3_reg;
        w4_next.cz = (cross3_reg == '0);
    end

    // leading-zero normalize: coarse steps
    always_comb
    begin
        int sh;
        w5_next = w4_reg;
        m5_next = m4_reg;
        for (int k = 0; k < 3; k++)
        begin
            sh = 32 >> k;
            if (m5_next < (AW'(1) << (pvta_pkg::ANG_TOP + 1 - sh)))
            begin
                m5_next    = m5_next << sh;
                w5_next.ax = w5_next.ax <<< sh;
                w5_next.ay = w5_next.ay <<< sh;
            end
        end
    end

    // fine steps
    always_comb
    begin
        int sh;
        w6_next = w5_reg;
        m6_next = m5_reg;
        for (int k = 0; k < 3; k++)
        begin
            sh = 4 >> k;
            if (m6_next < (AW'(1) << (pvta_pkg::ANG_TOP + 1 - sh)))
            begin
                m6_next    = m6_next << sh;
                w6_next.ax = w6_next.ax <<< sh;
                w6_next.ay = w6_next.ay <<< sh;
            end
        end
    end

    // quarter-turn pre-rotation into the right half plane
    always_comb
    begin
        w7_next    = w6_reg;
        w7_next.az = '0;
        if (w6_reg.ax < 0)
        begin
            if (w6_reg.ay >= 0)
            begin
                w7_next.ax = w6_reg.ay;
                w7_next.ay = -w6_reg.ax;
                w7_next.az = pvta_pkg::QUARTER_TURN;
            end
            else
            begin
                w7_next.ax = -w6_reg.ay;
                w7_next.ay = w6_reg.ax;
                w7_next.az = -pvta_pkg::QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (fe)
        begin
            v_reg <= {v_reg[6:1], vtx.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            dx1_reg   <= DW'(nx) - DW'(cx);
            dy1_reg   <= DW'(ny) - DW'(cy);
            r1x1_reg  <= DW'(cx) - DW'(px);
            r1y1_reg  <= DW'(py) - DW'(cy);
            r2y1_reg  <= DW'(cy) - DW'(ny);
            lone1_reg <= vtx.lone_point;

            p1_reg    <= r2y1_reg * r1x1_reg;
            p2_reg    <= r1y1_reg * dx1_reg;
            p3_reg    <= r1y1_reg * r2y1_reg;
            p4_reg    <= r1x1_reg * dx1_reg;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            lone2_reg <= lone1_reg;

            cross3_reg <= OW'(p1_reg) - OW'(p2_reg);
            dot3_reg   <= OW'(p3_reg) + OW'(p4_reg);
            lx3_reg    <= adx <<< pvta_pkg::LEN_FRAC;
            ly3_reg    <= ady <<< pvta_pkg::LEN_FRAC;
            dx3_reg    <= dx2_reg;
            dy3_reg    <= dy2_reg;
            lone3_reg  <= lone2_reg;

            w4_reg <= w4_next;
            m4_reg <= (mc > md) ? mc : md;
            w5_reg <= w5_next;
            m5_reg <= m5_next;
            w6_reg <= w6_next;
            w7_reg <= w7_next;
        end
    end

endmodule

FILE: design/pvta_queue.sv
module pvta_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  pvta_pkg::work_t  in_data,
    input  logic             in_valid,
    output logic             in_ready,
    output pvta_pkg::work_t  out_data,
    output logic             out_valid,
    input  logic             out_ready
);

    localparam int PW = pvta_pkg::QPTR_W;

    pvta_pkg::work_t mem [pvta_pkg::QDEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [PW:0]     cnt_reg;
    logic            push, pop;

    assign in_ready  = (cnt_reg != (PW+1)'(pvta_pkg::QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: design/pvta_back.sv
module pvta_back (
    input  logic             clk,
    input  logic             rst_n,
    input  pvta_pkg::work_t  q_data,
    input  logic             q_valid,
    output logic             q_ready,
    pvta_res_if.source       res
);

    localparam int NS = pvta_pkg::CORDIC_STEPS;
    localparam int AW = pvta_pkg::ANG_W;
    localparam int LW = pvta_pkg::LEN_W;
    localparam int ZW = pvta_pkg::Z_W;
    localparam int TW = pvta_pkg::T_W;
    localparam int MW = pvta_pkg::MUL_W;
    localparam int RW = MW - pvta_pkg::LEN_SH;
    localparam int DW = pvta_pkg::DIFF_W;

    logic            be;
    logic [NS:0]     v_reg;
    pvta_pkg::work_t st_reg [NS+1];

    logic                 vf_reg, vo_reg;
    logic [MW-1:0]        prod_reg;
    logic [32:0]          t_reg;
    logic signed [DW-1:0] dxf_reg, dyf_reg;
    logic                 lonef_reg, czf_reg;

    logic [16:0] o_dx_reg, o_dy_reg, o_len_reg, o_ang_reg;

    pvta_pkg::work_t      fin;
    logic [LW-2:0]        lxp;
    logic signed [TW-1:0] t;
    logic [MW-1:0]        rsum;
    logic [RW-1:0]        r;
    logic [17:0]          asum;
    logic [16:0]          len_sat, ang;

    assign be      = !vo_reg || res.ready;
    assign q_ready = be;

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        logic signed [AW-1:0] ax, ay;
        logic signed [LW-1:0] lx, ly;
        pvta_pkg::work_t      nxt;

        always_comb
        begin
            ax  = st_reg[i].ax;
            ay  = st_reg[i].ay;
            lx  = st_reg[i].lx;
            ly  = st_reg[i].ly;
            nxt = st_reg[i];
            if (ay >= 0)
            begin
                nxt.ax = ax + (ay >>> i);
                nxt.ay = ay - (ax >>> i);
                nxt.az = st_reg[i].az + pvta_pkg::atan_turn(i);
            end
            else
            begin
                nxt.ax = ax - (ay >>> i);
                nxt.ay = ay + (ax >>> i);
                nxt.az = st_reg[i].az - pvta_pkg::atan_turn(i);
            end
            if (ly >= 0)
            begin
                nxt.lx = lx + (ly >>> i);
                nxt.ly = ly - (lx >>> i);
            end
            else
            begin
                nxt.lx = lx - (ly >>> i);
                nxt.ly = ly + (lx >>> i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (be)
            begin
                st_reg[i+1] <= nxt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            st_reg[0] <= q_data;
        end
    end

    assign fin = st_reg[NS];

    always_comb
    begin
        lxp = (fin.lx < 0) ? '0 : fin.lx[LW-2:0];
        t   = TW'(signed'(35'sd2147483648)) - TW'(fin.az);
    end

    // rounding and saturation of the gain-corrected length and the angle
    always_comb
    begin
        rsum    = prod_reg + (MW'(1) << (pvta_pkg::LEN_SH - 1));
        r       = rsum[MW-1:pvta_pkg::LEN_SH];
        len_sat = (r > RW'((1 << (pvta_pkg::COORD_BITS + 1)) - 1))
                  ? 17'((1 << (pvta_pkg::COORD_BITS + 1)) - 1) : 17'(r);
        asum    = 18'((t_reg + 33'd32768) >> 16);
        ang     = (czf_reg || asum > 18'd65536) ? 17'd65536 : asum[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            vf_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (be)
        begin
            v_reg  <= {v_reg[NS-1:0], q_valid};
            vf_reg <= v_reg[NS];
            vo_reg <= vf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            prod_reg  <= MW'(lxp) * MW'(pvta_pkg::INV_GAIN_Q28);
            if (t < 0)
            begin
                t_reg <= '0;
            end
            else if (t > TW'(signed'(35'sd4294967296)))
            begin
                t_reg <= 33'h1_0000_0000;
            end
            else
            begin
                t_reg <= t[32:0];
            end
            dxf_reg   <= fin.dx;
            dyf_reg   <= fin.dy;
            lonef_reg <= fin.lone;
            czf_reg   <= fin.cz;

            o_dx_reg  <= lonef_reg ? '0 : 17'(dxf_reg);
            o_dy_reg  <= lonef_reg ? '0 : 17'(dyf_reg);
            o_len_reg <= lonef_reg ? '0 : len_sat;
            o_ang_reg <= lonef_reg ? '0 : ang;
        end
    end

    assign res.valid       = vo_reg;
    assign res.edge_dx     = o_dx_reg;
    assign res.edge_dy     = o_dy_reg;
    assign res.edge_length = o_len_reg;
    assign res.turn_angle  = o_ang_reg;

endmodule

FILE: design/polygon_vertex_edge_and_turn_angle.sv
// polygon vertex edge vector, edge length and turning angle
//
// channels: vtx takes one vertex with its neighbors per transaction (valid/ready),
// res returns one transaction per vertex in the same order: edge_dx/edge_dy
// (next minus current), edge_length (rounded, from a vectoring cordic) and
// turn_angle (pi - atan2(cross, dot), 65536 per turn, 65536 when cross is zero).
// a lone point gives all zeros.
// throughput: one vertex per cycle while res is taken, set by the fully
// pipelined front (diffs, products, normalize, pre-rotation) and one back stage
// per cordic iteration. stages: 7 front, then the queue, then CORDIC_STEPS + 3 back.
// reset: rst_n clears all valid bits and the queue; no transaction is in flight.
// stall: when res is not taken the back pipeline holds; the front keeps
// accepting until the 4-entry queue fills, then vtx.ready drops.
module polygon_vertex_edge_and_turn_angle (
    input  logic     clk,
    input  logic     rst_n,
    pvta_vtx_if.sink vtx,
    pvta_res_if.source res
);

    pvta_pkg::work_t f_data, b_data;
    logic            f_valid, f_ready, b_valid, b_ready;

    pvta_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .vtx     (vtx),
        .q_data  (f_data),
        .q_valid (f_valid),
        .q_ready (f_ready)
    );

    pvta_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (f_data),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .out_data  (b_data),
        .out_valid (b_valid),
        .out_ready (b_ready)
    );

    pvta_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (b_data),
        .q_valid (b_valid),
        .q_ready (b_ready),
        .res     (res)
    );

endmodule

FILE: design/pvta_chk.sv
module pvta_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [16:0] edge_dx,
    input logic [16:0] edge_dy,
    input logic [16:0] edge_length,
    input logic [16:0] turn_angle
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(edge_length) && $stable(turn_angle))
        else $error("stalled result changed");

    a_angle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> turn_angle <= 17'd65536)
        else $error("turn angle above full turn");

    // zero edge vector has zero length
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && edge_dx == '0 && edge_dy == '0 |-> edge_length == '0)
        else $error("zero edge with nonzero length");

    a_rst: assert property (@(posedge clk) $rose(rst_n) |-> !res_valid)
        else $error("result valid right after reset");

endmodule

bind polygon_vertex_edge_and_turn_angle pvta_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .edge_dx     (res.edge_dx),
    .edge_dy     (res.edge_dy),
    .edge_length (res.edge_length),
    .turn_angle  (res.turn_angle)
);

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic signed [15:0] px, py, cx, cy, nx, ny;
        logic               lone;
    } vertex_t;

    typedef struct {
        logic signed [16:0] dx, dy;
        logic [16:0]        len;
        logic [16:0]        ang;
    } edge_t;

    typedef struct {
        vertex_t v;
        logic    typed;
        edge_t   e;
    } row_t;

    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    pvta_vtx_if vtx();
    pvta_res_if res();

    polygon_vertex_edge_and_turn_angle dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vtx   (vtx),
        .res   (res)
    );

    edge_t  edge_q[$];
    int     errors;
    int     cycles;
    logic   calm;
    row_t   rows[$];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint absval(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // vectoring rotation: drives y toward zero, accumulates angle in z
    function automatic void rotate_vec(inout longint x, inout longint y, inout longint z);
        longint xs, ys;
        for (int i = 0; i < pvta_pkg::CORDIC_STEPS; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(pvta_pkg::atan_turn(i));
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(pvta_pkg::atan_turn(i));
            end
        end
    endfunction

    function automatic longint length_of(longint dx, longint dy);
        longint x, y, z, r;
        x = absval(dx) << pvta_pkg::LEN_FRAC;
        y = absval(dy) << pvta_pkg::LEN_FRAC;
        z = 0;
        rotate_vec(x, y, z);
        if (x < 0)
            x = 0;
        r = (x * 163008218 + (longint'(1) << (27 + pvta_pkg::LEN_FRAC)))
            >>> (28 + pvta_pkg::LEN_FRAC);
        return (r > 131071) ? 131071 : r;
    endfunction

    function automatic longint angle_of(longint crs, longint dt);
        longint m, x, y, z, t, ox;
        int msb, s;
        if (crs == 0)
            return 65536;
        m = absval(crs);
        if (absval(dt) > m)
            m = absval(dt);
        msb = 0;
        while (msb < 63 && (m >> (msb + 1)) != 0)
            msb++;
        s = (msb < 58) ? 58 - msb : 0;
        x = (dt < 0) ? -(absval(dt) << s) : (absval(dt) << s);
        y = (crs < 0) ? -(absval(crs) << s) : (absval(crs) << s);
        z = 0;
        // quadrant pre-rotation for obtuse cases
        if (x < 0)
        begin
            ox = x;
            if (y >= 0)
            begin
                x = y;
                y = -ox;
                z = 1073741824;
            end
            else
            begin
                x = -y;
                y = ox;
                z = -1073741824;
            end
        end
        rotate_vec(x, y, z);
        t = 64'sd2147483648 - z;
        if (t < 0)
            t = 0;
        if (t > 64'sd4294967296)
            t = 64'sd4294967296;
        m = (t + 32768) >>> 16;
        return (m > 65536) ? 65536 : m;
    endfunction

    function automatic edge_t predict_edge(vertex_t v);
        edge_t  e;
        longint dx, dy, r1x, r1y, r2x, r2y;
        if (v.lone)
        begin
            e.dx = '0;
            e.dy = '0;
            e.len = '0;
            e.ang = '0;
            return e;
        end
        dx = longint'(v.nx) - longint'(v.cx);
        dy = longint'(v.ny) - longint'(v.cy);
        r2x = dx;
        r2y = -dy;
        r1x = longint'(v.cx) - longint'(v.px);
        r1y = -(longint'(v.cy) - longint'(v.py));
        e.dx = dx[16:0];
        e.dy = dy[16:0];
        e.len = 17'(length_of(dx, dy));
        e.ang = 17'(angle_of(r2y * r1x - r1y * r2x, r1y * r2y + r1x * r2x));
        return e;
    endfunction

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic vertex_t random_vertex();
        vertex_t v;
        int      mode, k;
        logic signed [15:0] bx, by;
        mode = $urandom_range(0, 9);
        v.lone = (mode == 0);
        v.px = 16'($urandom); v.py = 16'($urandom);
        v.cx = 16'($urandom); v.cy = 16'($urandom);
        v.nx = 16'($urandom); v.ny = 16'($urandom);
        bx = 16'($urandom);
        by = 16'($urandom);
        case (mode)
            3, 4, 5:
            begin
                v.px = bx + 16'($signed($urandom_range(0, 200)) - 100);
                v.py = by + 16'($signed($urandom_range(0, 200)) - 100);
                v.cx = bx + 16'($signed($urandom_range(0, 200)) - 100);
                v.cy = by + 16'($signed($urandom_range(0, 200)) - 100);
                v.nx = bx + 16'($signed($urandom_range(0, 200)) - 100);
                v.ny = by + 16'($signed($urandom_range(0, 200)) - 100);
            end
            6:
            begin
                // collinear run, forward or backward
                k = $urandom_range(0, 6) - 3;
                bx = 16'($signed($urandom_range(0, 2000)) - 1000);
                by = 16'($signed($urandom_range(0, 2000)) - 1000);
                v.px = v.cx - bx;
                v.py = v.cy - by;
                v.nx = v.cx + 16'(k * bx);
                v.ny = v.cy + 16'(k * by);
            end
            7:
            begin
                if ($urandom_range(0, 1))
                begin
                    v.px = v.cx;
                    v.py = v.cy;
                end
                else
                begin
                    v.nx = v.cx;
                    v.ny = v.cy;
                end
            end
            8, 9:
            begin
                v.px = pick_coord(); v.py = pick_coord();
                v.cx = pick_coord(); v.cy = pick_coord();
                v.nx = pick_coord(); v.ny = pick_coord();
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic row_t mk(int px, int py, int cx, int cy, int nx, int ny,
                                bit lone, bit typed, int edx, int edy, int elen, int eang);
        row_t r;
        r.v.px = 16'(px); r.v.py = 16'(py);
        r.v.cx = 16'(cx); r.v.cy = 16'(cy);
        r.v.nx = 16'(nx); r.v.ny = 16'(ny);
        r.v.lone = lone;
        r.typed = typed;
        r.e.dx = 17'(edx); r.e.dy = 17'(edy);
        r.e.len = 17'(elen); r.e.ang = 17'(eang);
        return r;
    endfunction

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // one transaction on the vertex channel, at random preceded by an idle gap (valid low) unless calm is set
    task automatic send_vertex(vertex_t v, logic typed, edge_t e);
        if (!calm && $urandom_range(0, 99) < 16)
        begin
            vtx.valid <= 1'b0;
            @(posedge clk);
        end
        vtx.prev_x <= v.px; vtx.prev_y <= v.py;
        vtx.cur_x <= v.cx; vtx.cur_y <= v.cy;
        vtx.next_x <= v.nx; vtx.next_y <= v.ny;
        vtx.lone_point <= v.lone;
        vtx.valid <= 1'b1;
        @(posedge clk);
        while (!vtx.ready)
            @(posedge clk);
        if (typed)
            edge_q.push_back(e);
        else
            edge_q.push_back(predict_edge(v));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
            res.ready <= calm || ($urandom_range(0, 99) >= 14);
    end

    always @(posedge clk)
    begin
        edge_t x;
        if (rst_n && res.valid && res.ready)
        begin
            if (edge_q.size() == 0)
                report("result transaction with nothing expected");
            else
            begin
                x = edge_q.pop_front();
                if (res.edge_dx !== x.dx)
                    report($sformatf("edge_dx %0d want %0d", res.edge_dx, x.dx));
                if (res.edge_dy !== x.dy)
                    report($sformatf("edge_dy %0d want %0d", res.edge_dy, x.dy));
                if (res.edge_length !== x.len)
                    report($sformatf("edge_length %0d want %0d", res.edge_length, x.len));
                if (res.turn_angle !== x.ang)
                    report($sformatf("turn_angle %0d want %0d", res.turn_angle, x.ang));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        edge_t none;
        calm = 1'b0;
        none = '{default: '0};
        rst_n = 1'b0;
        vtx.valid = 1'b0;
        vtx.prev_x = '0; vtx.prev_y = '0;
        vtx.cur_x = '0; vtx.cur_y = '0;
        vtx.next_x = '0; vtx.next_y = '0;
        vtx.lone_point = 1'b0;

        // lone points, coincident points, extremes, turns of both senses
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0));
        rows.push_back(mk(-32768, 32767, 32767, -32768, -32768, 32767, 1, 1, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 65536));
        rows.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, 0, 1,
                          0, 0, 0, 65536));
        rows.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 0, 1, 0, 0, 0, 65536));
        rows.push_back(mk(0, 0, 10, 5, 10, 5, 0, 1, 0, 0, 0, 65536));
        rows.push_back(mk(0, 0, -32768, 0, 32767, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 32767, 0, -32768, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 0, -32768, 0, 32767, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, -32768, -32768, 32767, 32767, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 32767, -32768, -32768, 32767, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(-32768, 0, 0, 0, 32767, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 100, 0, 100, 100, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 100, 0, 100, -100, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 100, 0, 0, 10, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 100, 0, 0, -10, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 100, 0, 200, 1, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 100, 0, 200, -1, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 100, 0, 300, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 1, 1, 0, 2, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(-32768, 32767, 32767, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(32767, 32767, -32768, 32767, -32768, -32768, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(3, -7, 12, 40, -5, 9, 0, 0, 0, 0, 0, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_vertex(rows[i].v, rows[i].typed, rows[i].e);

        for (int n = 0; n < 1300; n++)
        begin
            calm <= (n >= 400 && n < 650);
            send_vertex(random_vertex(), 1'b0, none);
        end
        vtx.valid <= 1'b0;
        calm <= 1'b0;

        while (edge_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
